// ===== rtl/mpa_pkg.sv =====
package mpa_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_POOL    = 8;
   localparam int DATA_WIDTH  = 16;
   localparam int INDEX_WIDTH = 32;

   localparam int COL_BITS  = $clog2(MAX_COLS);
   localparam int SIZE_BITS = COL_BITS + 1;
   localparam int OFF_BITS  = $clog2(MAX_POOL);
   localparam int POOL_BITS = OFF_BITS + 1;
   localparam int STEP_BITS = $clog2(SIZE_BITS + 1);
   localparam int SLOT_WIDTH = DATA_WIDTH + INDEX_WIDTH;

   localparam int ROWS_CFG_BITS  = 11;
   localparam int POOL_CFG_BITS  = 4;
   localparam int PLANE_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_ROWS     = 3'd0,
      CSR_IN_COLS     = 3'd1,
      CSR_POOL_ROWS   = 3'd2,
      CSR_POOL_COLS   = 3'd3,
      CSR_PLANE_COUNT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  rows;
      logic [SIZE_BITS-1:0]  cols;
      logic [POOL_BITS-1:0]  prow;
      logic [POOL_BITS-1:0]  pcol;
      logic [PLANE_BITS-1:0] planes;
   } shape_type;

   typedef struct packed {
      logic                   in_window;
      logic                   first;
      logic                   last;
      logic                   plane_done;
      logic [COL_BITS-1:0]    slot;
      logic [INDEX_WIDTH-1:0] position;
   } win_info_type;

endpackage

// ===== rtl/max_pool_argmax_top.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_sample (signed Q8.8)
// rsp      out        rsp_valid/rsp_ready    rsp_max_value, rsp_max_position, rsp_plane_done
// csr      in         csr_wen (no wait)      csr_index, csr_wdata
//
// One sample is taken per cycle while req_ready is high; a window result passes through
// the line-store read register and then the output register after its last sample is accepted.
// After reset and after every register write, req_ready stays low while four 11-step
// shift-subtract dividers recompute the window offsets and output sizes.
// A stalled rsp channel holds one result in the output register; req_ready falls only
// when a second result is ready behind it.
module max_pool_argmax_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [mpa_pkg::DATA_WIDTH-1:0]     req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [mpa_pkg::DATA_WIDTH-1:0]     rsp_max_value,
   output logic [mpa_pkg::INDEX_WIDTH-1:0]           rsp_max_position,
   output logic                                      rsp_plane_done,
   input  logic                                      csr_wen,
   input  logic [mpa_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [mpa_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import mpa_pkg::*;

   logic [ROWS_CFG_BITS-1:0] in_rows_ff, in_rows_in;
   logic [ROWS_CFG_BITS-1:0] in_cols_ff, in_cols_in;
   logic [POOL_CFG_BITS-1:0] pool_rows_ff, pool_rows_in;
   logic [POOL_CFG_BITS-1:0] pool_cols_ff, pool_cols_in;
   logic [PLANE_BITS-1:0]    plane_count_ff, plane_count_in;
   logic                     pend_ff;
   shape_type                shape;
   win_info_type             info;
   logic                     walk_busy;
   logic                     room;
   logic                     take;

   always_comb begin
      in_rows_in     = in_rows_ff;
      in_cols_in     = in_cols_ff;
      pool_rows_in   = pool_rows_ff;
      pool_cols_in   = pool_cols_ff;
      plane_count_in = plane_count_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_ROWS:     in_rows_in     = csr_wdata[ROWS_CFG_BITS-1:0];
            CSR_IN_COLS:     in_cols_in     = csr_wdata[ROWS_CFG_BITS-1:0];
            CSR_POOL_ROWS:   pool_rows_in   = csr_wdata[POOL_CFG_BITS-1:0];
            CSR_POOL_COLS:   pool_cols_in   = csr_wdata[POOL_CFG_BITS-1:0];
            CSR_PLANE_COUNT: plane_count_in = csr_wdata[PLANE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff     <= ROWS_CFG_BITS'(28);
         in_cols_ff     <= ROWS_CFG_BITS'(28);
         pool_rows_ff   <= POOL_CFG_BITS'(2);
         pool_cols_ff   <= POOL_CFG_BITS'(2);
         plane_count_ff <= PLANE_BITS'(1);
         pend_ff        <= 1'b1;
      end else begin
         in_rows_ff     <= in_rows_in;
         in_cols_ff     <= in_cols_in;
         pool_rows_ff   <= pool_rows_in;
         pool_cols_ff   <= pool_cols_in;
         plane_count_ff <= plane_count_in;
         pend_ff        <= csr_wen;
      end
   end

   always_comb begin
      if (in_rows_ff == '0) begin
         shape.rows = SIZE_BITS'(1);
      end else if (in_rows_ff > MAX_COLS) begin
         shape.rows = SIZE_BITS'(MAX_COLS);
      end else begin
         shape.rows = SIZE_BITS'(in_rows_ff);
      end
      if (in_cols_ff == '0) begin
         shape.cols = SIZE_BITS'(1);
      end else if (in_cols_ff > MAX_COLS) begin
         shape.cols = SIZE_BITS'(MAX_COLS);
      end else begin
         shape.cols = SIZE_BITS'(in_cols_ff);
      end
      if (pool_rows_ff == '0) begin
         shape.prow = POOL_BITS'(1);
      end else if (pool_rows_ff > MAX_POOL) begin
         shape.prow = POOL_BITS'(MAX_POOL);
      end else begin
         shape.prow = POOL_BITS'(pool_rows_ff);
      end
      if (pool_cols_ff == '0) begin
         shape.pcol = POOL_BITS'(1);
      end else if (pool_cols_ff > MAX_POOL) begin
         shape.pcol = POOL_BITS'(MAX_POOL);
      end else begin
         shape.pcol = POOL_BITS'(pool_cols_ff);
      end
      shape.planes = (plane_count_ff == '0) ? PLANE_BITS'(1) : plane_count_ff;
   end

   assign req_ready = !pend_ff && !walk_busy && room;
   assign take      = req_valid && req_ready;

   mpa_walk walk (
      .clock(clock),
      .reset(reset),
      .shape(shape),
      .recalc(pend_ff),
      .advance(take),
      .busy(walk_busy),
      .info(info)
   );

   mpa_merge merge (
      .clock(clock),
      .reset(reset),
      .take(take),
      .sample(req_sample),
      .info(info),
      .room(room),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_max_value(rsp_max_value),
      .rsp_max_position(rsp_max_position),
      .rsp_plane_done(rsp_plane_done)
   );

`ifndef ASSERT_OFF
   a_no_take_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_wen |=> !(req_valid && req_ready))
      else $error("item accepted right after a register write");

   a_recalc_source: assert property (@(posedge clock) disable iff (reset)
      $rose(walk_busy) |-> $past(pend_ff))
      else $error("divider started without a pending recalculation");

   a_reset_blocks_input: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input ready directly after reset");
`endif

endmodule

// ===== rtl/mpa_ram.sv =====
module mpa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mpa_div.sv =====
module mpa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mpa_pkg::SIZE_BITS-1:0] dividend,
   input  logic [mpa_pkg::POOL_BITS-1:0] divisor,
   output logic                          busy,
   output logic [mpa_pkg::SIZE_BITS-1:0] quotient,
   output logic [mpa_pkg::POOL_BITS-1:0] remainder
);
   import mpa_pkg::*;

   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [POOL_BITS-1:0] rem_ff, rem_in;
   logic [POOL_BITS-1:0] den_ff, den_in;
   logic [SIZE_BITS-1:0] quo_ff, quo_in;
   logic [POOL_BITS:0]   rem_sh;
   logic [POOL_BITS:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SIZE_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         step_in = STEP_BITS'(SIZE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - STEP_BITS'(1);
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[POOL_BITS-1:0];
            quo_in = {quo_ff[SIZE_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[POOL_BITS-1:0];
            quo_in = {quo_ff[SIZE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy      = (step_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/mpa_walk.sv =====
module mpa_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  mpa_pkg::shape_type    shape,
   input  logic                  recalc,
   input  logic                  advance,
   output logic                  busy,
   output mpa_pkg::win_info_type info
);
   import mpa_pkg::*;

   logic [COL_BITS-1:0]    col_ff, col_in, row_ff, row_in;
   logic [COL_BITS-1:0]    wc_ff, wc_in, wr_ff, wr_in;
   logic [OFF_BITS-1:0]    ocol_ff, ocol_in, orow_ff, orow_in;
   logic [SIZE_BITS-1:0]   win_cols_ff, win_cols_in, win_rows_ff, win_rows_in;
   logic [PLANE_BITS-1:0]  plane_ff, plane_in, plane_next;
   logic [INDEX_WIDTH-1:0] elem_ff, elem_in;
   logic                   run_ff, run_in;
   logic                   load;
   logic [3:0]             lane_busy;
   logic [SIZE_BITS-1:0]   q_col, q_row, q_cols, q_rows;
   logic [POOL_BITS-1:0]   r_col, r_row, r_cols, r_rows;

   mpa_div div_col (
      .clock(clock), .reset(reset), .start(recalc),
      .dividend({1'b0, col_ff}), .divisor(shape.pcol),
      .busy(lane_busy[0]), .quotient(q_col), .remainder(r_col)
   );

   mpa_div div_row (
      .clock(clock), .reset(reset), .start(recalc),
      .dividend({1'b0, row_ff}), .divisor(shape.prow),
      .busy(lane_busy[1]), .quotient(q_row), .remainder(r_row)
   );

   mpa_div div_cols (
      .clock(clock), .reset(reset), .start(recalc),
      .dividend(shape.cols), .divisor(shape.pcol),
      .busy(lane_busy[2]), .quotient(q_cols), .remainder(r_cols)
   );

   mpa_div div_rows (
      .clock(clock), .reset(reset), .start(recalc),
      .dividend(shape.rows), .divisor(shape.prow),
      .busy(lane_busy[3]), .quotient(q_rows), .remainder(r_rows)
   );

   assign load = run_ff && !recalc && (lane_busy == '0);
   assign busy = run_ff;

   always_comb begin
      info.in_window  = ({1'b0, wr_ff} < win_rows_ff) && ({1'b0, wc_ff} < win_cols_ff);
      info.first      = (orow_ff == '0) && (ocol_ff == '0);
      info.last       = ({1'b0, orow_ff} + POOL_BITS'(1) == shape.prow)
                        && ({1'b0, ocol_ff} + POOL_BITS'(1) == shape.pcol);
      info.plane_done = ({1'b0, wr_ff} + SIZE_BITS'(1) == win_rows_ff)
                        && ({1'b0, wc_ff} + SIZE_BITS'(1) == win_cols_ff);
      info.slot       = wc_ff;
      info.position   = elem_ff;
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      wc_in       = wc_ff;
      wr_in       = wr_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      win_cols_in = win_cols_ff;
      win_rows_in = win_rows_ff;
      plane_in    = plane_ff;
      elem_in     = elem_ff;
      plane_next  = plane_ff + PLANE_BITS'(1);
      run_in      = recalc || (run_ff && !load);
      if (load) begin
         wc_in       = q_col[COL_BITS-1:0];
         ocol_in     = r_col[OFF_BITS-1:0];
         wr_in       = q_row[COL_BITS-1:0];
         orow_in     = r_row[OFF_BITS-1:0];
         win_cols_in = q_cols;
         win_rows_in = q_rows;
      end else if (advance) begin
         elem_in = elem_ff + INDEX_WIDTH'(1);
         if ({1'b0, col_ff} + SIZE_BITS'(1) >= shape.cols) begin
            col_in  = '0;
            wc_in   = '0;
            ocol_in = '0;
            if ({1'b0, row_ff} + SIZE_BITS'(1) >= shape.rows) begin
               row_in  = '0;
               wr_in   = '0;
               orow_in = '0;
               if (plane_next >= shape.planes) begin
                  plane_in = '0;
                  elem_in  = '0;
               end else begin
                  plane_in = plane_next;
               end
            end else begin
               row_in = row_ff + COL_BITS'(1);
               if ({1'b0, orow_ff} + POOL_BITS'(1) == shape.prow) begin
                  orow_in = '0;
                  wr_in   = wr_ff + COL_BITS'(1);
               end else begin
                  orow_in = orow_ff + OFF_BITS'(1);
               end
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
            if ({1'b0, ocol_ff} + POOL_BITS'(1) == shape.pcol) begin
               ocol_in = '0;
               wc_in   = wc_ff + COL_BITS'(1);
            end else begin
               ocol_in = ocol_ff + OFF_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wc_ff       <= '0;
         wr_ff       <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         win_cols_ff <= '0;
         win_rows_ff <= '0;
         plane_ff    <= '0;
         elem_ff     <= '0;
         run_ff      <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         wc_ff       <= wc_in;
         wr_ff       <= wr_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         win_cols_ff <= win_cols_in;
         win_rows_ff <= win_rows_in;
         plane_ff    <= plane_in;
         elem_ff     <= elem_in;
         run_ff      <= run_in;
      end
   end

endmodule

// ===== rtl/mpa_merge.sv =====
module mpa_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic signed [mpa_pkg::DATA_WIDTH-1:0] sample,
   input  mpa_pkg::win_info_type                 info,
   output logic                                  room,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mpa_pkg::DATA_WIDTH-1:0] rsp_max_value,
   output logic [mpa_pkg::INDEX_WIDTH-1:0]       rsp_max_position,
   output logic                                  rsp_plane_done
);
   import mpa_pkg::*;

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [DATA_WIDTH-1:0] s1_sample_ff;
   win_info_type                 s1_info_ff;
   logic [SLOT_WIDTH-1:0]        rd_data;
   logic [SLOT_WIDTH-1:0]        prev;
   logic [SLOT_WIDTH-1:0]        merged;
   logic signed [DATA_WIDTH-1:0] prev_max;
   logic                         fw_valid_ff;
   logic [COL_BITS-1:0]          fw_slot_ff;
   logic [SLOT_WIDTH-1:0]        fw_data_ff;
   logic                         emit;
   logic                         s1_go;
   logic                         wr_en;
   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff;
   logic [INDEX_WIDTH-1:0]       out_pos_ff;
   logic                         out_done_ff;

   mpa_ram #(
      .WIDTH(SLOT_WIDTH),
      .DEPTH(MAX_COLS)
   ) line_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(s1_info_ff.slot),
      .wr_data(merged),
      .rd_en(take),
      .rd_addr(info.slot),
      .rd_data(rd_data)
   );

   // The item just ahead may have written this slot at the edge where
   // this item read it, so its data is taken from the bypass register.
   always_comb begin
      prev     = (fw_valid_ff && (fw_slot_ff == s1_info_ff.slot)) ? fw_data_ff : rd_data;
      prev_max = prev[INDEX_WIDTH +: DATA_WIDTH];
      if (s1_info_ff.first || (s1_sample_ff > prev_max)) begin
         merged = {s1_sample_ff, s1_info_ff.position};
      end else begin
         merged = prev;
      end
      emit         = s1_info_ff.in_window && s1_info_ff.last;
      s1_go        = s1_valid_ff && (!emit || !out_valid_ff || rsp_ready);
      room         = !s1_valid_ff || s1_go;
      wr_en        = s1_go && s1_info_ff.in_window;
      s1_valid_in  = take || (s1_valid_ff && !s1_go);
      out_valid_in = (s1_go && emit) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            fw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sample_ff <= sample;
         s1_info_ff   <= info;
      end
      if (wr_en) begin
         fw_slot_ff <= s1_info_ff.slot;
         fw_data_ff <= merged;
      end
      if (s1_go && emit) begin
         out_value_ff <= merged[INDEX_WIDTH +: DATA_WIDTH];
         out_pos_ff   <= merged[INDEX_WIDTH-1:0];
         out_done_ff  <= s1_info_ff.plane_done;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_max_value    = out_value_ff;
   assign rsp_max_position = out_pos_ff;
   assign rsp_plane_done   = out_done_ff;

endmodule

// ===== tb/max_pool_argmax_top_tb.sv =====
`timescale 1ns / 100ps

module max_pool_argmax_top_tb;
   import mpa_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 60;
   localparam int RANDOM_RESULTS = 16;
   localparam logic signed [DATA_WIDTH-1:0] MOST_NEGATIVE = 16'sh8000;
   localparam logic signed [DATA_WIDTH-1:0] MOST_POSITIVE = 16'sh7FFF;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic [INDEX_WIDTH-1:0]       position;
      logic                         plane_done;
   } window_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [DATA_WIDTH-1:0]   req_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0]   rsp_max_value;
   logic [INDEX_WIDTH-1:0]         rsp_max_position;
   logic                           rsp_plane_done;
   logic                           csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_wdata = '0;

   // Shadow copy of the registers and the pooling state.
   logic [ROWS_CFG_BITS-1:0]       cfg_rows = 11'd28;
   logic [ROWS_CFG_BITS-1:0]       cfg_cols = 11'd28;
   logic [POOL_CFG_BITS-1:0]       cfg_prow = 4'd2;
   logic [POOL_CFG_BITS-1:0]       cfg_pcol = 4'd2;
   logic [PLANE_BITS-1:0]          cfg_planes = 16'd1;
   logic signed [DATA_WIDTH-1:0]   line_max [MAX_COLS];
   logic [INDEX_WIDTH-1:0]         line_pos [MAX_COLS];
   int unsigned                    col_cnt = 0;
   int unsigned                    row_cnt = 0;
   logic [PLANE_BITS-1:0]          plane_cnt = '0;
   logic [INDEX_WIDTH-1:0]         elem_cnt = '0;

   window_result_type              pending_results [$];
   int unsigned                    predicted_results = 0;
   int unsigned                    error_count = 0;
   int unsigned                    cycle_count = 0;
   bit                             sender_steady = 1'b0;
   bit                             receiver_steady = 1'b0;

   max_pool_argmax_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_position (rsp_max_position),
      .rsp_plane_done   (rsp_plane_done),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] random_data();
      case ($urandom_range(0, 7))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2: return DATA_WIDTH'($urandom_range(0, 3)) - 16'sd2;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 40) $display("[cycle %0d] mismatch: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic predict_pooling(input logic signed [DATA_WIDTH-1:0] data);
      int unsigned rows, cols, pr, pc, planes, win_rows, win_cols;
      int unsigned wr, wc, orow, ocol, k;
      window_result_type res;
      rows = bounded(cfg_rows, MAX_COLS);
      cols = bounded(cfg_cols, MAX_COLS);
      pr = bounded(cfg_prow, MAX_POOL);
      pc = bounded(cfg_pcol, MAX_POOL);
      planes = (cfg_planes == 0) ? 1 : cfg_planes;
      win_rows = rows / pr;
      win_cols = cols / pc;
      wr = row_cnt / pr;
      orow = row_cnt % pr;
      wc = col_cnt / pc;
      ocol = col_cnt % pc;
      if (wr < win_rows && wc < win_cols) begin
         k = wc % MAX_COLS;
         if ((orow == 0 && ocol == 0) || data > line_max[k]) begin
            line_max[k] = data;
            line_pos[k] = elem_cnt;
         end
         if (orow == pr - 1 && ocol == pc - 1) begin
            res.value = line_max[k];
            res.position = line_pos[k];
            res.plane_done = (wr == win_rows - 1 && wc == win_cols - 1);
            pending_results.push_back(res);
            predicted_results++;
         end
      end
      elem_cnt = elem_cnt + 1'b1;
      if (col_cnt + 1 >= cols) begin
         col_cnt = 0;
         if (row_cnt + 1 >= rows) begin
            row_cnt = 0;
            plane_cnt = plane_cnt + 1'b1;
            if (plane_cnt >= planes) begin
               plane_cnt = '0;
               elem_cnt = '0;
            end
         end else begin
            row_cnt++;
         end
      end else begin
         col_cnt++;
      end
   endtask

   task automatic send_sample(input logic signed [DATA_WIDTH-1:0] data);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= data;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_pooling(data);
   endtask

   task automatic pause_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_IN_ROWS:     cfg_rows = data[ROWS_CFG_BITS-1:0];
         CSR_IN_COLS:     cfg_cols = data[ROWS_CFG_BITS-1:0];
         CSR_POOL_ROWS:   cfg_prow = data[POOL_CFG_BITS-1:0];
         CSR_POOL_COLS:   cfg_pcol = data[POOL_CFG_BITS-1:0];
         CSR_PLANE_COUNT: cfg_planes = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] rows, cols, prow, pcol, planes);
      wait_drained();
      csr_write(CSR_IN_ROWS, rows);
      csr_write(CSR_IN_COLS, cols);
      csr_write(CSR_POOL_ROWS, prow);
      csr_write(CSR_POOL_COLS, pcol);
      csr_write(CSR_PLANE_COUNT, planes);
      csr_wen <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_sample(random_data());
   endtask

   task automatic finish_plane();
      while (row_cnt != 0 || col_cnt != 0) send_sample(random_data());
   endtask

   task automatic check_result();
      window_result_type exp;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result with no item pending: value %0d position %0d",
                                   rsp_max_value, rsp_max_position));
         return;
      end
      exp = pending_results.pop_front();
      if (rsp_max_value !== exp.value)
         report_mismatch($sformatf("max_value %0d, expected %0d", rsp_max_value, exp.value));
      if (rsp_max_position !== exp.position)
         report_mismatch($sformatf("max_position %0d, expected %0d",
                                   rsp_max_position, exp.position));
      if (rsp_plane_done !== exp.plane_done)
         report_mismatch($sformatf("plane_done %b, expected %b",
                                   rsp_plane_done, exp.plane_done));
   endtask

   initial begin : result_monitor
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = receiver_steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while ((rsp_valid && rsp_ready) !== 1'b1) @(posedge clock);
         check_result();
      end
   end

   task automatic test_reset_shape();
      send_random(2 * 28);
   endtask

   task automatic test_sample_extremes();
      logic signed [DATA_WIDTH-1:0] pattern [16];
      pattern = '{MOST_NEGATIVE, MOST_NEGATIVE, MOST_POSITIVE, 16'sd0,
                  MOST_NEGATIVE, MOST_NEGATIVE, MOST_POSITIVE, MOST_POSITIVE,
                  -16'sd1, 16'sd0, -16'sd2, MOST_NEGATIVE,
                  16'sd1, 16'sd0, -16'sd32767, MOST_NEGATIVE};
      configure(2, 4, 2, 2, 1);
      finish_plane();
      foreach (pattern[i]) send_sample(pattern[i]);
   endtask

   task automatic test_zero_registers();
      configure(0, 0, 0, 0, 0);
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(16'sd0);
      // Writes to unused register indexes must leave the shape alone.
      wait_drained();
      for (int idx = CSR_PLANE_COUNT + 1; idx < (1 << CSR_INDEX_BITS); idx++)
         csr_write(CSR_INDEX_BITS'(idx), CSR_DATA_BITS'($urandom));
      csr_wen <= 1'b0;
      send_sample(random_data());
      send_sample(random_data());
   endtask

   task automatic test_oversize_registers();
      // Fills line-store slots 0 to 15 under a clamped oversize column count.
      configure(0, 2047, 0, 15, 1);
      send_random(16 * MAX_POOL);
      configure(2047, 1, 15, 1, 2);
      send_random(3 * MAX_POOL);
   endtask

   task automatic test_window_too_large();
      configure(3, 5, 4, 6, 2);
      send_random(15);
      configure(7, 7, 8, 8, 1);
      send_random(20);
   endtask

   task automatic test_plane_count();
      configure(2, 4, 2, 2, 3);
      send_random(28);
      configure(2, 2, 2, 2, 65535);
      send_random(12);
      configure(2, 3, 2, 1, 1);
      send_random(6);
   endtask

   task automatic test_midstream_reconfig();
      configure(6, 10, 2, 3, 2);
      send_random(13);
      configure(5, 7, 3, 2, 1);
      send_random(12);
      configure(5, 8, 2, 4, 3);
      send_random(10);
      finish_plane();
   endtask

   task automatic test_drain_pause();
      configure(4, 6, 2, 3, 1);
      send_random(10);
      pause_for_results();
      sender_steady = 1'b1;
      send_random(10);
      pause_for_results();
      sender_steady = 1'b0;
      finish_plane();
   endtask

   task automatic test_random_shapes();
      int unsigned sent, first_result, count, pause_at, plane_size;
      logic [CSR_DATA_BITS-1:0] rows, cols, prow, pcol, planes;
      sent = 0;
      first_result = predicted_results;
      while (sent < RANDOM_ITEMS || predicted_results - first_result < RANDOM_RESULTS) begin
         rows = CSR_DATA_BITS'($urandom_range(0, 12));
         cols = CSR_DATA_BITS'($urandom_range(0, 16));
         if ($urandom_range(0, 3) == 0) rows = rows | (CSR_DATA_BITS'($urandom) & 16'hF800);
         if ($urandom_range(0, 3) == 0) cols = cols | (CSR_DATA_BITS'($urandom) & 16'hF800);
         prow = CSR_DATA_BITS'(($urandom_range(0, 5) == 0) ? $urandom_range(9, 15)
                                                            : $urandom_range(0, 4));
         pcol = CSR_DATA_BITS'(($urandom_range(0, 5) == 0) ? $urandom_range(9, 15)
                                                            : $urandom_range(0, 4));
         if ($urandom_range(0, 3) == 0) prow = prow | (CSR_DATA_BITS'($urandom) & 16'hFFF0);
         planes = ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                              : CSR_DATA_BITS'($urandom_range(0, 4));
         configure(rows, cols, prow, pcol, planes);
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         plane_size = bounded(cfg_rows, MAX_COLS) * bounded(cfg_cols, MAX_COLS);
         count = plane_size * $urandom_range(1, 2) + $urandom_range(0, 9);
         if (count > 40) count = 40;
         pause_at = $urandom_range(0, 1) ? $urandom_range(0, count - 1) : count;
         for (int i = 0; i < count; i++) begin
            if (i == pause_at) pause_for_results();
            send_sample(random_data());
         end
         sent += count;
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin : stimulus
      foreach (line_max[i]) begin
         line_max[i] = '0;
         line_pos[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_shape();
      test_sample_extremes();
      test_zero_registers();
      test_oversize_registers();
      test_window_too_large();
      test_plane_count();
      test_midstream_reconfig();
      test_drain_pause();
      test_random_shapes();
      wait_drained();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== max_pool_argmax_top.f =====
rtl/mpa_pkg.sv
rtl/mpa_ram.sv
rtl/mpa_div.sv
rtl/mpa_walk.sv
rtl/mpa_merge.sv
rtl/max_pool_argmax_top.sv
tb/max_pool_argmax_top_tb.sv
